// ===== rtl/qdd_pkg.sv =====
// Shared types, constants and the transition table of the quadrature detent decoder.
package qdd_pkg;

	localparam int CFG_IDX_W = 8;
	localparam int CFG_DATA_W = 16;

	localparam logic [CFG_IDX_W-1:0] CFG_DEBOUNCE_MS = 8'd0;
	localparam logic [CFG_IDX_W-1:0] CFG_SWAP_CHANNELS = 8'd1;
	localparam logic [CFG_IDX_W-1:0] CFG_STEPS_PER_DETENT = 8'd2;
	localparam logic [CFG_IDX_W-1:0] CFG_TAB_COUNT = 8'd3;

	localparam logic [15:0] DEBOUNCE_RST = 16'd100;
	localparam logic [2:0] STEPS_RST = 3'd4;
	localparam logic [4:0] TABS_RST = 5'd2;
	localparam logic [4:0] TABS_MAX = 5'd16;

	localparam int IN_TDATA_W = 40;
	localparam int OUT_TDATA_W = 72;

	typedef struct packed {
		logic [15:0] debounce_ms;
		logic swap_channels;
		logic [2:0] steps_per_detent;
		logic [4:0] tab_count;
	} cfg_t;

	typedef struct packed {
		logic chan_a;
		logic chan_b;
		logic button_level;
		logic [31:0] now_ms;
	} sample_t;

	typedef struct packed {
		logic signed [31:0] position;
		logic [3:0] selected_tab;
		logic [31:0] press_total;
		logic turned_cw;
		logic turned_ccw;
		logic press_seen;
	} result_t;

	// quarter step for {prev_code, code}
	function automatic logic signed [1:0] step_of(input logic [3:0] idx);
		logic signed [1:0] s;
		case (idx)
			4'd1, 4'd7, 4'd8, 4'd14: s = 2'sd1;
			4'd2, 4'd4, 4'd11, 4'd13: s = -2'sd1;
			default: s = 2'sd0;
		endcase
		return s;
	endfunction

endpackage

// ===== rtl/quadrature_detent_decoder.sv =====
// Top level of the quadrature detent decoder: input register, core and result register.
//
//  channel   direction  handshake            payload
//  s_*       in         s_tvalid/s_tready    s_tdata: samples
//  m_*       out        m_tvalid/m_tready    m_tdata: results
//  cfg_*     in         cfg_valid/cfg_ready  cfg_index, cfg_data
//
// One result per sample, one sample per cycle sustained while m_tready stays high;
// a sample passes the input register and then the result register before m_tvalid
// rises, and a stalled result can hold it in the input register.
// arst_n resets the valid flags, core state and configuration, not the data registers.
// A stalled result holds; the input register keeps taking samples while the
// result register drains, and holds off once both are full. cfg_ready is always high.
module quadrature_detent_decoder (
	input logic clk,
	input logic arst_n,
	input logic s_tvalid,
	output logic s_tready,
	// [0] chan_a, [1] chan_b, [2] button_level, [34:3] now_ms, [39:35] zero
	input logic [qdd_pkg::IN_TDATA_W-1:0] s_tdata,
	output logic m_tvalid,
	input logic m_tready,
	// [31:0] position, [35:32] selected_tab, [67:36] press_total,
	// [68] turned_cw, [69] turned_ccw, [70] press_seen, [71] zero
	output logic [qdd_pkg::OUT_TDATA_W-1:0] m_tdata,
	input logic cfg_valid,
	output logic cfg_ready,
	input logic [qdd_pkg::CFG_IDX_W-1:0] cfg_index,
	input logic [qdd_pkg::CFG_DATA_W-1:0] cfg_data
);

	qdd_pkg::cfg_t cfg;
	qdd_pkg::sample_t sample_s1;
	qdd_pkg::result_t result, result_q;
	logic valid_s1;
	logic m_tvalid_q;
	logic advance;

	assign cfg_ready = 1'b1;
	assign advance = valid_s1 && (!m_tvalid_q || m_tready);
	assign s_tready = !valid_s1 || advance;

	qdd_cfg_regs u_cfg (
		.clk(clk),
		.arst_n(arst_n),
		.wr_en(cfg_valid && cfg_ready),
		.wr_index(cfg_index),
		.wr_data(cfg_data),
		.cfg(cfg)
	);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else if (s_tready) begin
			valid_s1 <= s_tvalid;
		end
	end

	always_ff @(posedge clk) begin
		if (s_tvalid && s_tready) begin
			sample_s1.chan_a <= s_tdata[0];
			sample_s1.chan_b <= s_tdata[1];
			sample_s1.button_level <= s_tdata[2];
			sample_s1.now_ms <= s_tdata[34:3];
		end
	end

	qdd_core u_core (
		.clk(clk),
		.arst_n(arst_n),
		.cfg(cfg),
		.sample(sample_s1),
		.advance(advance),
		.result(result)
	);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			m_tvalid_q <= 1'b0;
		end else if (advance) begin
			m_tvalid_q <= 1'b1;
		end else if (m_tready) begin
			m_tvalid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (advance) begin
			result_q <= result;
		end
	end

	assign m_tvalid = m_tvalid_q;
	assign m_tdata = {1'b0, result_q.press_seen, result_q.turned_ccw, result_q.turned_cw,
		result_q.press_total, result_q.selected_tab, result_q.position};

endmodule

// ===== rtl/qdd_cfg_regs.sv =====
// Configuration register file of the quadrature detent decoder.
module qdd_cfg_regs (
	input logic clk,
	input logic arst_n,
	input logic wr_en,
	input logic [qdd_pkg::CFG_IDX_W-1:0] wr_index,
	input logic [qdd_pkg::CFG_DATA_W-1:0] wr_data,
	output qdd_pkg::cfg_t cfg
);

	qdd_pkg::cfg_t cfg_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cfg_q.debounce_ms <= qdd_pkg::DEBOUNCE_RST;
			cfg_q.swap_channels <= 1'b0;
			cfg_q.steps_per_detent <= qdd_pkg::STEPS_RST;
			cfg_q.tab_count <= qdd_pkg::TABS_RST;
		end else if (wr_en) begin
			unique case (wr_index)
				qdd_pkg::CFG_DEBOUNCE_MS: cfg_q.debounce_ms <= wr_data;
				qdd_pkg::CFG_SWAP_CHANNELS: cfg_q.swap_channels <= wr_data[0];
				qdd_pkg::CFG_STEPS_PER_DETENT: cfg_q.steps_per_detent <= wr_data[2:0];
				qdd_pkg::CFG_TAB_COUNT: cfg_q.tab_count <= wr_data[4:0];
				default: ;
			endcase
		end
	end

	assign cfg = cfg_q;

endmodule

// ===== rtl/qdd_core.sv =====
// Decoder state and the per-sample update of rotation, tab and button.
module qdd_core (
	input logic clk,
	input logic arst_n,
	input qdd_pkg::cfg_t cfg,
	input qdd_pkg::sample_t sample,
	input logic advance,
	output qdd_pkg::result_t result
);

	logic [1:0] prev_code_q;
	logic primed_q;
	logic signed [3:0] step_sum_q;
	logic [31:0] pos_count_q;
	logic [3:0] tab_index_q;
	logic [31:0] press_count_q;
	logic [31:0] last_press_time_q;
	logic prev_button_q;

	logic [1:0] code;
	logic [4:0] tabs;
	logic [3:0] tabs_m1;
	logic [2:0] lim;
	logic signed [4:0] sum_next;
	logic cw, ccw, pressed, btn_edge;
	logic signed [3:0] sum_upd;
	logic [31:0] pos_upd;
	logic [3:0] tab_rot, tab_upd;
	logic [31:0] elapsed;

	function automatic logic [3:0] tab_fwd(input logic [3:0] t, input logic [4:0] n);
		logic [4:0] inc;
		inc = {1'b0, t} + 5'd1;
		return (inc >= n) ? 4'd0 : inc[3:0];
	endfunction

	function automatic logic [3:0] tab_bwd(input logic [3:0] t, input logic [3:0] nm1);
		return (t == 4'd0 || t > nm1) ? nm1 : t - 4'd1;
	endfunction

	always_comb begin
		code = cfg.swap_channels ? {sample.chan_b, sample.chan_a}
			: {sample.chan_a, sample.chan_b};
		if (cfg.tab_count == 5'd0) begin
			tabs = 5'd1;
		end else if (cfg.tab_count > qdd_pkg::TABS_MAX) begin
			tabs = qdd_pkg::TABS_MAX;
		end else begin
			tabs = cfg.tab_count;
		end
		tabs_m1 = 4'(tabs - 5'd1);
		lim = (cfg.steps_per_detent == 3'd0) ? 3'd1 : cfg.steps_per_detent;

		// sum stays within +-6 between samples, so 5 bits hold the new value
		sum_next = 5'(step_sum_q) + 5'(qdd_pkg::step_of({prev_code_q, code}));
		cw = 1'b0;
		ccw = 1'b0;
		sum_upd = step_sum_q;
		pos_upd = pos_count_q;
		tab_rot = tab_index_q;
		if (primed_q) begin
			sum_upd = sum_next[3:0];
			if (sum_next >= $signed({2'b00, lim})) begin
				cw = 1'b1;
				sum_upd = 4'sd0;
				pos_upd = pos_count_q + 32'd1;
				tab_rot = tab_fwd(tab_index_q, tabs);
			end else if (sum_next <= -$signed({2'b00, lim})) begin
				ccw = 1'b1;
				sum_upd = 4'sd0;
				pos_upd = pos_count_q - 32'd1;
				tab_rot = tab_bwd(tab_index_q, tabs_m1);
			end
		end

		elapsed = sample.now_ms - last_press_time_q;
		btn_edge = sample.button_level != prev_button_q;
		pressed = btn_edge && !sample.button_level && (elapsed > {16'd0, cfg.debounce_ms});
		tab_upd = pressed ? tab_fwd(tab_rot, tabs) : tab_rot;

		result.position = pos_upd;
		result.selected_tab = tab_upd;
		result.press_total = pressed ? press_count_q + 32'd1 : press_count_q;
		result.turned_cw = cw;
		result.turned_ccw = ccw;
		result.press_seen = pressed;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			prev_code_q <= 2'd0;
			primed_q <= 1'b0;
			step_sum_q <= 4'sd0;
			pos_count_q <= 32'd0;
			tab_index_q <= 4'd0;
			press_count_q <= 32'd0;
			last_press_time_q <= 32'd0;
			prev_button_q <= 1'b1;
		end else if (advance) begin
			prev_code_q <= code;
			primed_q <= 1'b1;
			step_sum_q <= sum_upd;
			pos_count_q <= pos_upd;
			tab_index_q <= tab_upd;
			press_count_q <= result.press_total;
			if (pressed) begin
				last_press_time_q <= sample.now_ms;
			end
			prev_button_q <= sample.button_level;
		end
	end

endmodule

// ===== rtl/qdd_checker.sv =====
// Port-level checks of the quadrature detent decoder, bound to the top level.
module qdd_checker (
	input logic clk,
	input logic arst_n,
	input logic s_tvalid,
	input logic s_tready,
	input logic m_tvalid,
	input logic m_tready,
	input logic [qdd_pkg::OUT_TDATA_W-1:0] m_tdata
);

	// a stalled result transaction holds
	a_out_hold: assert property (@(posedge clk) disable iff (!arst_n)
		m_tvalid && !m_tready |=> m_tvalid && $stable(m_tdata))
		else $error("result changed while stalled");

	// one detent direction per sample
	a_dir_excl: assert property (@(posedge clk) disable iff (!arst_n)
		m_tvalid |-> !(m_tdata[68] && m_tdata[69]))
		else $error("cw and ccw on the same result");

	// every input transaction is followed by a raised m_tvalid
	a_latency: assert property (@(posedge clk) disable iff (!arst_n)
		s_tvalid && s_tready |-> ##2 m_tvalid)
		else $error("no result after input transaction");

	// padding bit above the flags stays clear
	a_pad_zero: assert property (@(posedge clk) disable iff (!arst_n)
		m_tvalid |-> !m_tdata[71])
		else $error("result padding bit set");

endmodule

bind quadrature_detent_decoder qdd_checker u_qdd_checker (.*);
